[rtl/idc_pkg.sv]
// Shared types and constants for the iterated dilation counter.
package idc_pkg;

  localparam int SIZE_W    = 9;
  localparam int STEP_W    = 16;
  localparam int PIX_W     = 32;
  localparam int IDX_W     = 16;
  localparam int ACT_W     = 2;
  localparam int REG_IDX_W = 2;

  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RUN  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOP  = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_STEP_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLS       = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROWS       = 2'd2;

  localparam logic [PIX_W-1:0] PIX_MAX = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_APPLY,
    ST_APPLY_END,
    ST_FINISH
  } state_t;

  // control for one scan position, issued with the pixel read
  typedef struct packed {
    logic valid;
    logic real_px;    // inside the active image, pixel is read
    logic col_ok;     // x below the active width
    logic first_col;  // x is zero
    logic top_row;    // y is zero
    logic center_ok;  // a center row (y - 1) exists
  } scan_ctl_t;

  typedef struct packed {
    logic we;
    logic grow;
  } mark_t;

endpackage

[rtl/idc_mark_unit.sv]
// Neighborhood window and line buffer that produce the per-pixel grow marks.
module idc_mark_unit import idc_pkg::*; #(
  parameter int MAX_COLS = 256,
  localparam int XW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  scan_ctl_t     scan_in,
  input  logic [XW-1:0] scan_x,
  input  logic          nz_new,
  output mark_t         mark
);

  // per column: {nonzero of row y-2, nonzero of row y-1}
  logic [1:0]    lb [MAX_COLS];
  logic [1:0]    lb_q;
  scan_ctl_t     s1;
  logic [XW-1:0] x1;
  logic          ctr_p, ctr_pp, up_p, dn_p;
  logic [1:0]    lbv;
  logic          up_now, ctr_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1 <= scan_in;
    end
  end

  always_ff @(posedge clk) begin
    x1 <= scan_x;
    if (scan_in.valid && scan_in.col_ok) begin
      lb_q <= lb[scan_x];
    end
    if (s1.valid && s1.col_ok) begin
      lb[x1] <= {ctr_now, nz_new};
    end
  end

  always_comb begin
    lbv     = s1.top_row ? 2'b00 : lb_q;
    up_now  = lbv[1];
    ctr_now = s1.col_ok ? lbv[0] : 1'b0;
  end

  // window over columns x-2, x-1, x of the center row
  always_ff @(posedge clk) begin
    if (s1.valid) begin
      ctr_pp <= s1.first_col ? 1'b0 : ctr_p;
      ctr_p  <= ctr_now;
      up_p   <= up_now;
      dn_p   <= nz_new;
    end
  end

  always_comb begin
    mark.we   = s1.valid && !s1.first_col && s1.center_ok;
    mark.grow = ctr_p | ctr_pp | ctr_now | up_p | dn_p;
  end

endmodule

[rtl/iterated_dilation_counter_2d.sv]
// Top level: pixel store, pass sequencer and command port of the dilation counter.
//
//  channel  | ports                                      | handshake
//  ---------+--------------------------------------------+---------------------------
//  config   | cfg_we, cfg_addr, cfg_wdata                | write when cfg_we high
//  command  | action, pixel_index, pixel_value           | taken when start && !busy
//  result   | read_value, done_res                       | res_strobe, one cycle
//
// Load and read items may follow back to back; the result strobes in the
// cycle after the item is taken (read data comes from the pixel store's
// registered read port). A run item holds busy high for its whole duration:
// each pass is a raster scan that builds the grow marks through a two-row
// line buffer, a decision state, then an update sweep over the single
// read/write store. At most step_count passes run; once no zero pixel is
// left, the passes collapse into bulk-add sweeps, each bounded by the
// remaining count and by the most negative pixel reaching zero, and an
// all-zero image stops the run early. Reset restores the register defaults;
// the pixel store is not cleared. The receiver cannot stall results.
module iterated_dilation_counter_2d import idc_pkg::*; #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [REG_IDX_W-1:0]    cfg_addr,
  input  logic [STEP_W-1:0]       cfg_wdata,
  input  logic                    start,
  output logic                    busy,
  input  logic [ACT_W-1:0]        action,
  input  logic [IDX_W-1:0]        pixel_index,
  input  logic signed [PIX_W-1:0] pixel_value,
  output logic                    res_strobe,
  output logic signed [PIX_W-1:0] read_value,
  output logic                    done_res
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int XW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  state_t state, state_next;

  // configuration
  logic [STEP_W-1:0] step_count;
  logic [SIZE_W-1:0] cols_in_use, rows_in_use;
  logic [CW-1:0]     cols_eff;
  logic [RW-1:0]     rows_eff;

  // command decode
  logic          accept;
  logic          in_store;
  logic [AW-1:0] cmd_addr;

  // pixel store and grow marks
  logic [PIX_W-1:0] img [DEPTH];
  logic             marks [DEPTH];
  logic [PIX_W-1:0] img_q;
  logic             img_rd_en;
  logic [AW-1:0]    img_rd_addr;
  logic             img_wr_en;
  logic [AW-1:0]    img_wr_addr;
  logic [PIX_W-1:0] img_wr_data;

  // scan
  logic [CW-1:0] sx;
  logic [RW-1:0] sy;
  logic [AW:0]   rd_addr;
  logic [AW:0]   mk_addr;   // also the pixel count once a scan is done
  scan_ctl_t     s0;
  logic          s1_real;
  logic          nz_new;
  mark_t         mark;

  // pass statistics
  logic             any_zero, any_nonzero, any_neg;
  logic [PIX_W-1:0] min_neg;
  logic [PIX_W:0]   neg_mag;
  logic [STEP_W-1:0] bulk_inc, inc_next;

  // update sweep
  logic [STEP_W-1:0] remaining;
  logic [STEP_W-1:0] inc;
  logic [AW:0]       ap;
  logic              a1_valid;
  logic [AW-1:0]     a1_addr;
  logic              mk_q;
  logic [PIX_W:0]    sum;
  logic [PIX_W-1:0]  apply_val;

  // result
  logic rsp_valid, rsp_is_read, rsp_in_range, rsp_done;

  // sizes out of range clamp to 1 .. MAX
  always_comb begin
    if (cols_in_use == '0) begin
      cols_eff = CW'(1);
    end else if (int'(cols_in_use) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(cols_in_use);
    end
    if (rows_in_use == '0) begin
      rows_eff = RW'(1);
    end else if (int'(rows_in_use) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(rows_in_use);
    end
  end

  assign accept   = start && !busy;
  assign in_store = 32'(pixel_index) < DEPTH;
  assign cmd_addr = AW'(pixel_index);

  // scan position control; the extra column and row flush the window
  always_comb begin
    s0.valid     = (state == ST_SCAN);
    s0.real_px   = (sx < cols_eff) && (sy < rows_eff);
    s0.col_ok    = (sx < cols_eff);
    s0.first_col = (sx == '0);
    s0.top_row   = (sy == '0);
    s0.center_ok = (sy != '0);
  end

  assign nz_new = s1_real && (img_q != '0);

  idc_mark_unit #(
    .MAX_COLS (MAX_COLS)
  ) u_mark (
    .clk     (clk),
    .rst     (rst),
    .scan_in (s0),
    .scan_x  (sx[XW-1:0]),
    .nz_new  (nz_new),
    .mark    (mark)
  );

  // with no zero pixel left every pixel gains one per pass, until the most
  // negative one reaches zero
  always_comb begin
    neg_mag  = -{min_neg[PIX_W-1], min_neg};
    bulk_inc = (any_neg && (neg_mag < {{(PIX_W+1-STEP_W){1'b0}}, remaining}))
               ? neg_mag[STEP_W-1:0] : remaining;
    inc_next = any_zero ? STEP_W'(1) : bulk_inc;
  end

  // saturating add at the top of the signed range
  always_comb begin
    sum       = {img_q[PIX_W-1], img_q} + {{(PIX_W+1-STEP_W){1'b0}}, inc};
    apply_val = (!sum[PIX_W] && sum[PIX_W-1]) ? PIX_MAX : sum[PIX_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && action == ACT_RUN) begin
          state_next = (step_count == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sx == cols_eff && sy == rows_eff) state_next = ST_SCAN_END;
      end
      ST_SCAN_END: state_next = ST_DECIDE;
      ST_DECIDE: begin
        state_next = any_nonzero ? ST_APPLY : ST_FINISH;
      end
      ST_APPLY: begin
        if (ap + 1'b1 == mk_addr) state_next = ST_APPLY_END;
      end
      ST_APPLY_END: begin
        state_next = (remaining == '0) ? ST_FINISH : ST_SCAN;
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs and store port selection
  always_comb begin
    busy        = (state != ST_IDLE);
    img_rd_en   = 1'b0;
    img_rd_addr = cmd_addr;
    unique case (state)
      ST_IDLE: begin
        img_rd_en   = accept && (action == ACT_READ) && in_store;
        img_rd_addr = cmd_addr;
      end
      ST_SCAN: begin
        img_rd_en   = s0.real_px;
        img_rd_addr = rd_addr[AW-1:0];
      end
      ST_APPLY: begin
        img_rd_en   = 1'b1;
        img_rd_addr = ap[AW-1:0];
      end
      default: img_rd_en = 1'b0;
    endcase

    if (a1_valid) begin
      img_wr_en   = mk_q;
      img_wr_addr = a1_addr;
      img_wr_data = apply_val;
    end else begin
      img_wr_en   = (state == ST_IDLE) && accept && (action == ACT_LOAD) && in_store;
      img_wr_addr = cmd_addr;
      img_wr_data = pixel_value;
    end

    res_strobe = rsp_valid;
    done_res   = rsp_valid && rsp_done;
    read_value = (rsp_valid && rsp_is_read && rsp_in_range) ? img_q : '0;
  end

  // memories
  always_ff @(posedge clk) begin
    if (img_rd_en) img_q <= img[img_rd_addr];
    if (img_wr_en) img[img_wr_addr] <= img_wr_data;
  end

  always_ff @(posedge clk) begin
    if (mark.we) marks[mk_addr[AW-1:0]] <= mark.grow;
    if (state == ST_APPLY) mk_q <= marks[ap[AW-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step_count  <= 16'd65535;
      cols_in_use <= 9'd256;
      rows_in_use <= 9'd256;
      rsp_valid   <= 1'b0;
      s1_real     <= 1'b0;
      a1_valid    <= 1'b0;
    end else begin
      state    <= state_next;
      s1_real  <= s0.valid && s0.real_px;
      a1_valid <= (state == ST_APPLY);
      rsp_valid <= ((state == ST_IDLE) && accept && (action != ACT_RUN))
                   || (state == ST_FINISH);
      if (cfg_we) begin
        case (cfg_addr)
          REG_STEP_COUNT: step_count  <= cfg_wdata;
          REG_COLS:       cols_in_use <= cfg_wdata[SIZE_W-1:0];
          REG_ROWS:       rows_in_use <= cfg_wdata[SIZE_W-1:0];
          default:        ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    a1_addr <= ap[AW-1:0];
    if (mark.we) mk_addr <= mk_addr + 1'b1;

    if (s1_real) begin
      if (img_q == '0) begin
        any_zero <= 1'b1;
      end else begin
        any_nonzero <= 1'b1;
        if (img_q[PIX_W-1] && (!any_neg || $signed(img_q) < $signed(min_neg))) begin
          any_neg <= 1'b1;
          min_neg <= img_q;
        end
      end
    end

    case (state)
      ST_IDLE: begin
        remaining    <= step_count;
        rsp_is_read  <= (action == ACT_READ);
        rsp_in_range <= in_store;
        rsp_done     <= (action != ACT_NOP);
        sx           <= '0;
        sy           <= '0;
        rd_addr      <= '0;
        mk_addr      <= '0;
        any_zero     <= 1'b0;
        any_nonzero  <= 1'b0;
        any_neg      <= 1'b0;
      end
      ST_SCAN: begin
        if (s0.real_px) rd_addr <= rd_addr + 1'b1;
        if (sx == cols_eff) begin
          sx <= '0;
          sy <= sy + 1'b1;
        end else begin
          sx <= sx + 1'b1;
        end
      end
      ST_DECIDE: begin
        inc       <= inc_next;
        remaining <= remaining - inc_next;
        ap        <= '0;
      end
      ST_APPLY: ap <= ap + 1'b1;
      ST_APPLY_END: begin
        sx          <= '0;
        sy          <= '0;
        rd_addr     <= '0;
        mk_addr     <= '0;
        any_zero    <= 1'b0;
        any_nonzero <= 1'b0;
        any_neg     <= 1'b0;
      end
      ST_FINISH: begin
        rsp_is_read <= 1'b0;
        rsp_done    <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule
